// ===== design/krkd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the keyboard report key event differ.
// No dependencies; used by krkd_lane, krkd_merge and the top level.
package krkd_pkg;

    localparam int CODE_W         = 8;
    localparam int INPUT_SLOTS    = 6;
    localparam int KEY_SLOTS_DEF  = 6;
    localparam int TDATA_IN_W     = INPUT_SLOTS * CODE_W;

    localparam logic [CODE_W-1:0] CODE_EMPTY = 8'h00;
    localparam logic [CODE_W-1:0] CODE_NONE  = 8'hFF;

    // Per-slot findings of one lane.
    typedef struct packed {
        logic down;  // current slot code is new
        logic up;    // previous slot code disappeared
    } t_lane_flags;

    // Codes 0 and 255 never give an event.
    function automatic logic reportable(input logic [CODE_W-1:0] code);
        reportable = (code != CODE_EMPTY) && (code != CODE_NONE);
    endfunction

endpackage

// ===== design/keyboard_report_key_event_diff.sv =====
`timescale 1ns / 1ps
// Top level of the keyboard report key event differ: stores the last report,
// runs one comparison lane per slot and merges the events. Depends on
// krkd_pkg, krkd_lane and krkd_merge.
//
// Usage:
//   Input channel (s_*): one request carries a report of six 8-bit key codes;
//   only the first KEY_SLOTS slots (at most six) are compared and remembered.
//   Output channel (m_*): one request per key event. m_tdata is the code,
//   m_tuser is 1 for key-down and 0 for key-up, m_tlast marks the final event
//   of a report. A report that changes nothing gives no request at all.
//   Order per slot i: down event of new slot i first, then up event of old
//   slot i. Codes 0 and 255 never give an event.
// Timing:
//   A report loads its pending events into the merge stage when accepted, and
//   its first event then moves into the output register.
//   Events leave at one per cycle while the output is not stalled; a report
//   gives up to 12 events, and the next report is accepted in the cycle its
//   last event moves into the output register. A report without events does
//   not hold the merge stage; the event count, not the comparison, sets the rate.
// Reset and stall:
//   Reset clears the stored report to all zero and drops pending events.
//   When m_tready is low the output register holds its event, the pending
//   events wait with it, and s_tready stays low while events are pending.
module keyboard_report_key_event_diff #(
    parameter int KEY_SLOTS = krkd_pkg::KEY_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [krkd_pkg::TDATA_IN_W-1:0]   s_tdata,   // slot0_code .. slot5_code, 8 bits each
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [krkd_pkg::CODE_W-1:0]       m_tdata,   // event_code[7:0]
    output logic                              m_tuser,   // is_press
    output logic                              m_tlast    // last_event
);

    // Slots that take part in the comparison.
    localparam int ACTIVE = (KEY_SLOTS > krkd_pkg::INPUT_SLOTS) ?
                            krkd_pkg::INPUT_SLOTS : KEY_SLOTS;

    logic [ACTIVE-1:0][krkd_pkg::CODE_W-1:0] cur_codes;
    logic [ACTIVE-1:0][krkd_pkg::CODE_W-1:0] r_prev;
    krkd_pkg::t_lane_flags [ACTIVE-1:0]      lane_flags;
    logic                                    merge_ready;
    logic                                    accept;

    // Unpack the active slots; the rest of the report is ignored.
    always_comb begin
        for (int i = 0; i < ACTIVE; i++) begin
            cur_codes[i] = s_tdata[i*krkd_pkg::CODE_W +: krkd_pkg::CODE_W];
        end
    end

    assign s_tready = merge_ready;
    assign accept   = s_tvalid && merge_ready;

    // Advance the stored report on every accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (accept) begin
            r_prev <= cur_codes;
        end
    end

    for (genvar g = 0; g < ACTIVE; g++) begin : g_lane
        krkd_lane #(
            .SLOTS (ACTIVE)
        ) u_lane (
            .i_cur_code  (cur_codes[g]),
            .i_prev_code (r_prev[g]),
            .i_cur_all   (cur_codes),
            .i_prev_all  (r_prev),
            .o_flags     (lane_flags[g])
        );
    end

    krkd_merge #(
        .LANES (ACTIVE)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_flags      (lane_flags),
        .i_cur_codes  (cur_codes),
        .i_prev_codes (r_prev),
        .o_ready      (merge_ready),
        .o_tvalid     (m_tvalid),
        .i_tready     (m_tready),
        .o_tdata      (m_tdata),
        .o_tuser      (m_tuser),
        .o_tlast      (m_tlast)
    );

endmodule

// ===== design/krkd_lane.sv =====
`timescale 1ns / 1ps
// One comparison lane: judges current and previous code of a single slot.
// Depends on krkd_pkg.
module krkd_lane #(
    parameter int SLOTS = krkd_pkg::KEY_SLOTS_DEF
) (
    input  logic [krkd_pkg::CODE_W-1:0]            i_cur_code,
    input  logic [krkd_pkg::CODE_W-1:0]            i_prev_code,
    input  logic [SLOTS-1:0][krkd_pkg::CODE_W-1:0] i_cur_all,
    input  logic [SLOTS-1:0][krkd_pkg::CODE_W-1:0] i_prev_all,
    output krkd_pkg::t_lane_flags                  o_flags
);

    logic cur_seen;
    logic prev_seen;

    always_comb begin
        cur_seen  = 1'b0;
        prev_seen = 1'b0;
        for (int j = 0; j < SLOTS; j++) begin
            if (i_prev_all[j] == i_cur_code) begin
                cur_seen = 1'b1;
            end
            if (i_cur_all[j] == i_prev_code) begin
                prev_seen = 1'b1;
            end
        end
        o_flags.down = krkd_pkg::reportable(i_cur_code) && !cur_seen;
        o_flags.up   = krkd_pkg::reportable(i_prev_code) && !prev_seen;
    end

endmodule

// ===== design/krkd_merge.sv =====
`timescale 1ns / 1ps
// Merge stage (depends on krkd_pkg): holds the pending events of one report
// and sends one per cycle when not stalled, in slot order, via a register.
module krkd_merge #(
    parameter int LANES = krkd_pkg::KEY_SLOTS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_load,
    input  krkd_pkg::t_lane_flags [LANES-1:0]      i_flags,
    input  logic [LANES-1:0][krkd_pkg::CODE_W-1:0] i_cur_codes,
    input  logic [LANES-1:0][krkd_pkg::CODE_W-1:0] i_prev_codes,
    output logic                                   o_ready,
    output logic                                   o_tvalid,
    input  logic                                   i_tready,
    output logic [krkd_pkg::CODE_W-1:0]            o_tdata,
    output logic                                   o_tuser,
    output logic                                   o_tlast
);

    localparam int EVENTS = 2 * LANES;

    logic [EVENTS-1:0]                      r_mask;
    logic [EVENTS-1:0]                      n_mask;
    logic [EVENTS-1:0][krkd_pkg::CODE_W-1:0] r_codes;
    logic [EVENTS-1:0]                      load_mask;
    logic [EVENTS-1:0]                      pick;
    logic [EVENTS-1:0]                      rest;
    logic [krkd_pkg::CODE_W-1:0]            pick_code;
    logic                                   pick_press;
    logic                                   out_free;
    logic                                   emit;

    logic                                   r_out_valid;
    logic [krkd_pkg::CODE_W-1:0]            r_out_code;
    logic                                   r_out_press;
    logic                                   r_out_last;

    // Even bit 2i: down event of slot i; odd bit 2i+1: up event of slot i.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            load_mask[2*i]   = i_flags[i].down;
            load_mask[2*i+1] = i_flags[i].up;
        end
    end

    assign pick     = r_mask & (~r_mask + {{(EVENTS-1){1'b0}}, 1'b1});
    assign rest     = r_mask & ~pick;
    assign out_free = !r_out_valid || i_tready;
    assign emit     = (r_mask != '0) && out_free;
    assign o_ready  = (r_mask == '0) || (emit && (rest == '0));

    always_comb begin
        pick_code  = '0;
        pick_press = 1'b0;
        for (int k = 0; k < EVENTS; k++) begin
            pick_code = pick_code | ({krkd_pkg::CODE_W{pick[k]}} & r_codes[k]);
            if ((k % 2) == 0) begin
                pick_press = pick_press | pick[k];
            end
        end
    end

    always_comb begin
        if (i_load) begin
            n_mask = load_mask;
        end else if (emit) begin
            n_mask = rest;
        end else begin
            n_mask = r_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < LANES; i++) begin
                r_codes[2*i]   <= i_cur_codes[i];
                r_codes[2*i+1] <= i_prev_codes[i];
            end
        end
        if (emit) begin
            r_out_code  <= pick_code;
            r_out_press <= pick_press;
            r_out_last  <= (rest == '0);
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_code;
    assign o_tuser  = r_out_press;
    assign o_tlast  = r_out_last;

    // A new report only lands when the previous one is fully drained.
    a_load_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> ((r_mask == '0) || (emit && (rest == '0))))
        else $error("report loaded over pending events");

    // Without a load, pending events can only be removed, never added.
    a_mask_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_load |=> ((r_mask & ~$past(r_mask)) == '0))
        else $error("pending event appeared without a load");

    // The selected event is always a single one.
    a_pick_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> $onehot(pick))
        else $error("event pick is not one-hot");

    // Never present code 0 or 255 as an event.
    a_code_reportable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_code != krkd_pkg::CODE_EMPTY &&
                         r_out_code != krkd_pkg::CODE_NONE))
        else $error("unreportable code on output");

endmodule
